[rtl/dfiir_pkg.sv]
// Shared types, constants and the microcode table of the sixth-order IIR filter.
package dfiir_pkg;

	localparam int FILTER_ORDER_DEF = 6;
	localparam int MAX_TAPS         = 6;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 16;
	localparam int HIST_Y_W = 24;
	localparam int OPB_W    = 24;
	localparam int PROD_W   = COEF_W + OPB_W;
	localparam int ACC_W    = 48;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_B_0_3 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_B_4_6 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_A_1_3 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_A_4_6 = 3'd3;
	localparam logic [63:0] CFG_B_0_3_RST = 64'd16384;

	// coefficient select codes: b0..b6 then a1..a6
	localparam int COEF_SEL_W = 4;
	localparam logic [COEF_SEL_W-1:0] COEF_B0 = 4'd0;
	localparam logic [COEF_SEL_W-1:0] COEF_A1 = 4'd7;

	// program addresses
	typedef logic [3:0] step_t;
	localparam step_t STEP_FIRST    = 4'd0;
	localparam step_t STEP_LAST_MAC = 4'd12;
	localparam step_t STEP_DRAIN    = 4'd13;
	localparam step_t STEP_ROUND    = 4'd14;
	localparam step_t STEP_EMIT     = 4'd15;

	typedef enum logic [1:0] {
		ACC_NONE = 2'd0,
		ACC_LOAD = 2'd1,
		ACC_ADD  = 2'd2,
		ACC_SUB  = 2'd3
	} acc_op_t;

	typedef enum logic [1:0] {
		SRC_X0 = 2'd0,
		SRC_XH = 2'd1,
		SRC_YH = 2'd2
	} src_t;

	typedef enum logic [1:0] {
		JMP_NONE         = 2'd0,
		JMP_TAP_GT_ORDER = 2'd1,
		JMP_END          = 2'd2
	} jmp_t;

	// one control word of the program
	typedef struct packed {
		acc_op_t               op;
		logic [COEF_SEL_W-1:0] coef;
		src_t                  src;
		logic [2:0]            tap;
		jmp_t                  jmp;
		step_t                 target;
		logic                  round;
		logic                  emit;
	} uword_t;

	// datapath controls issued by the sequencer
	typedef struct packed {
		acc_op_t               op;
		logic [COEF_SEL_W-1:0] coef;
		src_t                  src;
		logic [2:0]            tap;
		logic                  round;
		logic                  emit;
	} ctl_t;

	// Program: b0*x, then bk*x[n-k] and ak*y[n-k] for each tap, drain, round, emit.
	function automatic uword_t ucode(input step_t step);
		uword_t     w;
		logic [2:0] tap;
		tap      = 3'((5'(step) + 5'd1) >> 1);
		w.op     = ACC_NONE;
		w.coef   = COEF_B0;
		w.src    = SRC_X0;
		w.tap    = 3'd0;
		w.jmp    = JMP_NONE;
		w.target = STEP_FIRST;
		w.round  = 1'b0;
		w.emit   = 1'b0;
		case (step)
			STEP_FIRST: begin
				w.op = ACC_LOAD;
			end
			STEP_DRAIN: begin
				w.op = ACC_NONE;
			end
			STEP_ROUND: begin
				w.round = 1'b1;
			end
			STEP_EMIT: begin
				w.emit = 1'b1;
				w.jmp  = JMP_END;
			end
			default: begin
				w.tap = tap;
				if (step[0]) begin
					w.op     = ACC_ADD;
					w.coef   = COEF_B0 + COEF_SEL_W'(tap);
					w.src    = SRC_XH;
					w.jmp    = JMP_TAP_GT_ORDER;
					w.target = STEP_DRAIN;
				end else begin
					w.op   = ACC_SUB;
					w.coef = COEF_A1 + COEF_SEL_W'(tap) - 4'd1;
					w.src  = SRC_YH;
				end
			end
		endcase
		return w;
	endfunction

endpackage

[rtl/direct_form_iir_order6.sv]
// Top level of the sixth-order direct-form-I IIR filter.
// Usage:
//   Input words arrive on s_axis_* (one signed Q1.15 sample per word); filtered
//   samples leave on m_axis_* (signed Q1.15, saturated). Coefficients are
//   written on cfg_* (index 0: b0..b3, 1: b4..b6, 2: a1..a3, 3: a4..a6, each
//   coefficient signed Q2.14, lowest in bits 15:0); cfg_ready is always high.
//   Write coefficients only while no sample is in flight.
// Program:
//   A microcoded program runs b0*x, then bk*x[n-k] and ak*y[n-k] per tap on
//   one shared 16x24 multiplier, then a drain, a rounding and an emit step.
//   Taps beyond FILTER_ORDER are skipped straight to the drain step. A new
//   sample is taken only after the program of the last one has run its emit
//   step, since the multiply-accumulate is shared. The emit step writes the
//   result into the output register that drives m_axis.
// Reset:
//   arst_n clears both histories, sets b0 = 1.0 and all other coefficients to
//   zero, so the filter passes samples through.
// Backpressure:
//   The output register holds a result until m_axis_tready; the next sample is
//   accepted meanwhile, and its emit step waits only if the old word still sits.
module direct_form_iir_order6 #(
	parameter int FILTER_ORDER = dfiir_pkg::FILTER_ORDER_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [dfiir_pkg::SAMPLE_W-1:0]      s_axis_tdata,  // [15:0] sample_in
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [dfiir_pkg::SAMPLE_W-1:0]      m_axis_tdata,  // [15:0] sample_out
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dfiir_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [63:0]                         cfg_data
);
	import dfiir_pkg::*;

	logic busy;
	logic in_accept;
	logic out_free;
	ctl_t ctl;
	logic signed [SAMPLE_W-1:0] sample_out;

	// take a new sample only between programs
	assign s_axis_tready = !busy;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	// output register can take a word this cycle
	assign out_free      = !m_axis_tvalid || m_axis_tready;

	dfiir_seq #(
		.FILTER_ORDER(FILTER_ORDER)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.out_free  (out_free),
		.busy      (busy),
		.ctl       (ctl)
	);

	dfiir_dp #(
		.FILTER_ORDER(FILTER_ORDER)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_accept  (in_accept),
		.sample_in  (s_axis_tdata),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.ctl        (ctl),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.sample_out (sample_out)
	);

	assign m_axis_tdata = sample_out;

`ifndef SYNTH
	// an accepted sample starts the program with a fresh accumulator load
	a_start_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (ctl.op == ACC_LOAD))
		else $error("program did not start after sample accept");

	// never overwrite a result the receiver has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result emitted over a pending output word");

	// output valid only comes from an emit step
	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(ctl.emit))
		else $error("output valid without an emit step");
`endif

endmodule

[rtl/dfiir_seq.sv]
// Microcode sequencer: step counter, program table and conditional jumps.
module dfiir_seq #(
	parameter int FILTER_ORDER = dfiir_pkg::FILTER_ORDER_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_accept,
	input  logic            out_free,
	output logic            busy,
	output dfiir_pkg::ctl_t ctl
);
	import dfiir_pkg::*;

	step_t  step_q;
	logic   busy_q;
	uword_t cw;
	logic   skip;
	logic   hold;

	assign cw   = ucode(step_q);
	// taps beyond the filter order are skipped straight to the drain step
	assign skip = (cw.jmp == JMP_TAP_GT_ORDER) && (cw.tap > 3'(FILTER_ORDER));
	assign hold = cw.emit && !out_free;

	always_comb begin
		ctl.op    = (busy_q && !skip) ? cw.op : ACC_NONE;
		ctl.coef  = cw.coef;
		ctl.src   = cw.src;
		ctl.tap   = cw.tap;
		ctl.round = busy_q && cw.round;
		ctl.emit  = busy_q && cw.emit && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= STEP_FIRST;
		end else if (!busy_q) begin
			step_q <= STEP_FIRST;
			if (in_accept) begin
				busy_q <= 1'b1;
			end
		end else if (skip) begin
			step_q <= cw.target;
		end else if (hold) begin
			step_q <= step_q;
		end else if (cw.jmp == JMP_END) begin
			busy_q <= 1'b0;
			step_q <= STEP_FIRST;
		end else begin
			step_q <= step_q + 4'd1;
		end
	end

	assign busy = busy_q;

endmodule

[rtl/dfiir_dp.sv]
// Datapath: coefficients, histories, shared multiplier, accumulator and rounding.
module dfiir_dp #(
	parameter int FILTER_ORDER = dfiir_pkg::FILTER_ORDER_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_accept,
	input  logic signed [dfiir_pkg::SAMPLE_W-1:0] sample_in,
	input  logic                                cfg_we,
	input  logic [dfiir_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [63:0]                         cfg_data,
	input  dfiir_pkg::ctl_t                     ctl,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic signed [dfiir_pkg::SAMPLE_W-1:0] sample_out
);
	import dfiir_pkg::*;

	localparam int IDX_W = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1;

	logic [63:0] b03_q;
	logic [47:0] b46_q;
	logic [47:0] a13_q;
	logic [47:0] a46_q;

	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [SAMPLE_W-1:0] xh_q [FILTER_ORDER];
	logic signed [HIST_Y_W-1:0] yh_q [FILTER_ORDER];
	logic signed [HIST_Y_W-1:0] y_q;

	logic signed [COEF_W-1:0] coef;
	logic signed [OPB_W-1:0]  opb;
	logic [2:0]               tm1;
	logic [IDX_W-1:0]         hidx;
	logic                     hvalid;
	logic signed [SAMPLE_W-1:0] xh_rd;
	logic signed [HIST_Y_W-1:0] yh_rd;

	logic signed [PROD_W-1:0] prod_s1;
	acc_op_t                  op_s1;
	logic signed [ACC_W-1:0]  acc_q;

	logic signed [ACC_W-1:0]    rnd;
	logic signed [ACC_W-1:0]    rsh;
	logic signed [HIST_Y_W-1:0] y_sat;
	logic signed [HIST_Y_W:0]   ys;
	logic signed [HIST_Y_W:0]   osh;
	logic signed [SAMPLE_W-1:0] o_sat;
	logic signed [SAMPLE_W-1:0] out_q;
	logic                       out_valid_q;

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b03_q <= CFG_B_0_3_RST;
			b46_q <= '0;
			a13_q <= '0;
			a46_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_B_0_3: b03_q <= cfg_data;
				CFG_B_4_6: b46_q <= cfg_data[47:0];
				CFG_A_1_3: a13_q <= cfg_data[47:0];
				CFG_A_4_6: a46_q <= cfg_data[47:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (ctl.coef)
			4'd0:    coef = b03_q[15:0];
			4'd1:    coef = b03_q[31:16];
			4'd2:    coef = b03_q[47:32];
			4'd3:    coef = b03_q[63:48];
			4'd4:    coef = b46_q[15:0];
			4'd5:    coef = b46_q[31:16];
			4'd6:    coef = b46_q[47:32];
			4'd7:    coef = a13_q[15:0];
			4'd8:    coef = a13_q[31:16];
			4'd9:    coef = a13_q[47:32];
			4'd10:   coef = a46_q[15:0];
			4'd11:   coef = a46_q[31:16];
			4'd12:   coef = a46_q[47:32];
			default: coef = '0;
		endcase
	end

	// history read for tap k reads entry k-1
	assign tm1    = ctl.tap - 3'd1;
	assign hvalid = tm1 < 3'(FILTER_ORDER);
	assign hidx   = tm1[IDX_W-1:0];
	assign xh_rd  = hvalid ? xh_q[hidx] : '0;
	assign yh_rd  = hvalid ? yh_q[hidx] : '0;

	// samples enter at x*2^7 so both product kinds share 36 fraction bits
	always_comb begin
		case (ctl.src)
			SRC_X0:  opb = {x_q[SAMPLE_W-1], x_q, 7'd0};
			SRC_XH:  opb = {xh_rd[SAMPLE_W-1], xh_rd, 7'd0};
			SRC_YH:  opb = yh_rd;
			default: opb = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= ACC_NONE;
		end else begin
			op_s1 <= ctl.op;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= coef * opb;
	end

	always_ff @(posedge clk) begin
		case (op_s1)
			ACC_LOAD: acc_q <= ACC_W'(prod_s1);
			ACC_ADD:  acc_q <= acc_q + ACC_W'(prod_s1);
			ACC_SUB:  acc_q <= acc_q - ACC_W'(prod_s1);
			default:  acc_q <= acc_q;
		endcase
	end

	// round to Q2.22 and saturate
	always_comb begin
		rnd = acc_q + 48'sd8192;
		rsh = rnd >>> 14;
		if (rsh > 48'sd8388607) begin
			y_sat = 24'sh7FFFFF;
		end else if (rsh < -48'sd8388608) begin
			y_sat = -24'sh800000;
		end else begin
			y_sat = rsh[HIST_Y_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.round) begin
			y_q <= y_sat;
		end
	end

	// round to Q1.15 and saturate
	always_comb begin
		ys  = {y_q[HIST_Y_W-1], y_q} + 25'sd64;
		osh = ys >>> 7;
		if (osh > 25'sd32767) begin
			o_sat = 16'sh7FFF;
		end else if (osh < -25'sd32768) begin
			o_sat = -16'sh8000;
		end else begin
			o_sat = osh[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			x_q <= sample_in;
		end
	end

	// shift histories when the result commits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FILTER_ORDER; i++) begin
				xh_q[i] <= '0;
				yh_q[i] <= '0;
			end
		end else if (ctl.emit) begin
			xh_q[0] <= x_q;
			yh_q[0] <= y_q;
			for (int i = 1; i < FILTER_ORDER; i++) begin
				xh_q[i] <= xh_q[i-1];
				yh_q[i] <= yh_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_q <= o_sat;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

endmodule
